>>> sv/prim_mst_dense_assert.svh
// Assertion macros shared by the checker of the spanning tree block.
`ifndef PRIM_MST_DENSE_ASSERT_SVH
`define PRIM_MST_DENSE_ASSERT_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define PMD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prim_mst_dense check failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define PMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prim_mst_dense check failed");

`endif

>>> sv/pmd_pkg.sv
// Package with types and constants of the spanning tree block.
package pmd_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int IDX_FW    = 6;
  localparam int WEIGHT_FW = 16;
  localparam int VCOUNT_W  = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic                REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic [IDX_FW-1:0]    row;
    logic [IDX_FW-1:0]    col;
    logic [WEIGHT_FW-1:0] weight;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_FW-1:0]    vertex;
    logic [IDX_FW-1:0]    parent;
    logic [WEIGHT_FW-1:0] edge_weight;
    logic                 reached;
    logic                 last_edge;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FIND,
    ST_WAIT,
    ST_RELAX,
    ST_DRAIN,
    ST_REPORT
  } state_t;

endpackage

>>> sv/pmd_cell.sv
// One vertex cell: key, parent and tree flag, plus one stage of the minimum search chain.
module pmd_cell #(
  parameter int MAX_VERTICES = pmd_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = pmd_pkg::WEIGHT_BITS_DEF,
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int NW = $clog2(MAX_VERTICES + 1),
  localparam int KW = WEIGHT_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VW-1:0]          my_idx,
  input  logic [NW-1:0]          n_act,
  input  logic                   init,
  input  logic                   mark_en,
  input  logic [VW-1:0]          mark_idx,
  input  logic                   upd_en,
  input  logic [VW-1:0]          upd_idx,
  input  logic [VW-1:0]          upd_par,
  input  logic [WEIGHT_BITS-1:0] upd_w,
  input  logic                   tok_in_vld,
  input  logic [KW-1:0]          tok_in_key,
  input  logic [VW-1:0]          tok_in_idx,
  input  logic                   tok_in_found,
  output logic                   tok_out_vld,
  output logic [KW-1:0]          tok_out_key,
  output logic [VW-1:0]          tok_out_idx,
  output logic                   tok_out_found,
  output logic [VW-1:0]          parent,
  output logic                   has_parent
);

  localparam logic [KW-1:0] KEY_INF = KW'(1) << WEIGHT_BITS;

  logic [KW-1:0] key;
  logic          in_tree;
  logic          active;
  logic          wins;
  logic          relax;

  assign active = ({1'b0, my_idx} < (VW + 1)'(n_act));
  assign wins   = active && !in_tree && (key < tok_in_key);
  assign relax  = upd_en && (upd_idx == my_idx) && (upd_w != '0) && !in_tree &&
                  ({1'b0, upd_w} < key);

  // Vertex state: cleared at run start, marked when chosen, lowered on relaxation.
  always_ff @(posedge clk) begin
    if (rst || init) begin
      key        <= (my_idx == '0) ? '0 : KEY_INF;
      in_tree    <= 1'b0;
      has_parent <= 1'b0;
      parent     <= '0;
    end else begin
      if (mark_en && (mark_idx == my_idx)) begin
        in_tree <= 1'b1;
      end
      if (relax) begin
        key        <= {1'b0, upd_w};
        parent     <= upd_par;
        has_parent <= 1'b1;
      end
    end
  end

  // Search token stage: takes this vertex when its key is strictly lower.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_vld <= 1'b0;
    end else begin
      tok_out_vld <= tok_in_vld;
    end
    if (wins) begin
      tok_out_key   <= key;
      tok_out_idx   <= my_idx;
      tok_out_found <= 1'b1;
    end else begin
      tok_out_key   <= tok_in_key;
      tok_out_idx   <= tok_in_idx;
      tok_out_found <= tok_in_found;
    end
  end

endmodule

>>> sv/prim_mst_dense.sv
// Top level of the Prim spanning tree block over a dense weight matrix.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------
//  input    | start && !busy               | in_item (in_item_t)
//  result   | result_valid, one cycle      | result (result_t)
//  config   | psel && penable && pwrite    | paddr, pwdata
//
// Matrix entries are taken one per cycle while busy is low; an entry without last
// leaves the block ready. After the last entry busy stays high through at most
// n - 1 full rounds and the report: each round sends the search token through all
// cells, then reads one matrix row through the single memory read port. A round that
// finds no vertex goes straight to the report.
// Reset clears the control state and restores vertex_count to 64.
// Results cannot be stalled; busy stays high until the final result is shown.
module prim_mst_dense #(
  parameter int MAX_VERTICES = pmd_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = pmd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pmd_pkg::in_item_t              in_item,
  output logic                           result_valid,
  output pmd_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pmd_pkg::PADDR_W-1:0]    paddr,
  input  logic [pmd_pkg::PDATA_W-1:0]    pwdata,
  output logic [pmd_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int KW = WEIGHT_BITS + 1;
  localparam int AW = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam logic [KW-1:0] KEY_INF = KW'(1) << WEIGHT_BITS;
  localparam logic [WEIGHT_BITS-1:0] WMASK =
    (WEIGHT_BITS > pmd_pkg::WEIGHT_FW) ? WEIGHT_BITS'({pmd_pkg::WEIGHT_FW{1'b1}})
                                       : {WEIGHT_BITS{1'b1}};

  pmd_pkg::state_t state, state_next;

  logic [pmd_pkg::VCOUNT_W-1:0] vertex_count;
  logic [NW-1:0] n_reg;
  logic [NW-1:0] n_act;
  logic [NW-1:0] cnt;
  logic [NW-1:0] round;
  logic [VW-1:0] u_reg;
  logic          accept;
  logic          in_range;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   mem_we;

  logic          cell_init;
  logic          tok_inject;
  logic          mark_en;
  logic          relax_issue;
  logic          rep_issue;

  logic          rd_vld_d;
  logic [VW-1:0] rd_idx_d;
  logic          rep_vld_d;
  logic [VW-1:0] rep_v;
  logic [VW-1:0] rep_p;
  logic          rep_has;
  logic          rep_last;

  logic          tok_vld   [MAX_VERTICES+1];
  logic [KW-1:0] tok_key   [MAX_VERTICES+1];
  logic [VW-1:0] tok_idx   [MAX_VERTICES+1];
  logic          tok_found [MAX_VERTICES+1];
  logic [VW-1:0] cell_par  [MAX_VERTICES];
  logic          cell_has  [MAX_VERTICES];
  logic [VW-1:0] par_sel;

  assign accept   = start && !busy;
  assign in_range = (32'(in_item.row) < MAX_VERTICES) && (32'(in_item.col) < MAX_VERTICES);
  assign busy     = (state != pmd_pkg::ST_IDLE) || rep_vld_d;
  assign pready   = 1'b1;

  // Active vertex count: zero acts as one, large values saturate.
  always_comb begin
    if (vertex_count == '0) begin
      n_act = NW'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_act = NW'(MAX_VERTICES);
    end else begin
      n_act = NW'(vertex_count);
    end
  end

  // Configuration register transactions.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pmd_pkg::VCOUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == pmd_pkg::REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[pmd_pkg::VCOUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == pmd_pkg::REG_VERTEX_COUNT) begin
      prdata = pmd_pkg::PDATA_W'(vertex_count);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pmd_pkg::ST_IDLE: begin
        if (accept && in_item.last) state_next = pmd_pkg::ST_INIT;
      end
      pmd_pkg::ST_INIT: begin
        state_next = (n_reg == NW'(1)) ? pmd_pkg::ST_IDLE : pmd_pkg::ST_FIND;
      end
      pmd_pkg::ST_FIND: state_next = pmd_pkg::ST_WAIT;
      pmd_pkg::ST_WAIT: begin
        if (tok_vld[MAX_VERTICES]) begin
          state_next = tok_found[MAX_VERTICES] ? pmd_pkg::ST_RELAX : pmd_pkg::ST_REPORT;
        end
      end
      pmd_pkg::ST_RELAX: begin
        if (cnt == n_reg - NW'(1)) state_next = pmd_pkg::ST_DRAIN;
      end
      pmd_pkg::ST_DRAIN: begin
        state_next = (({1'b0, round} + (NW + 1)'(2)) < {1'b0, n_reg}) ?
                     pmd_pkg::ST_FIND : pmd_pkg::ST_REPORT;
      end
      pmd_pkg::ST_REPORT: begin
        if (cnt == n_reg - NW'(1)) state_next = pmd_pkg::ST_IDLE;
      end
      default: state_next = pmd_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cell_init   = 1'b0;
    tok_inject  = 1'b0;
    mark_en     = 1'b0;
    relax_issue = 1'b0;
    rep_issue   = 1'b0;
    mem_we      = 1'b0;
    case (state)
      pmd_pkg::ST_IDLE:   mem_we = accept && in_range;
      pmd_pkg::ST_INIT:   cell_init = 1'b1;
      pmd_pkg::ST_FIND:   tok_inject = 1'b1;
      pmd_pkg::ST_WAIT:   mark_en = tok_vld[MAX_VERTICES] && tok_found[MAX_VERTICES];
      pmd_pkg::ST_RELAX:  relax_issue = 1'b1;
      pmd_pkg::ST_DRAIN:  relax_issue = 1'b0;
      pmd_pkg::ST_REPORT: rep_issue = 1'b1;
      default:            mem_we = 1'b0;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (accept && in_item.last) begin
      n_reg <= n_act;
    end
    if (state == pmd_pkg::ST_INIT) begin
      round <= '0;
    end else if (state == pmd_pkg::ST_DRAIN) begin
      round <= round + NW'(1);
    end
    if (mark_en) begin
      u_reg <= tok_idx[MAX_VERTICES];
    end
    if ((state_next == pmd_pkg::ST_REPORT) && (state != pmd_pkg::ST_REPORT)) begin
      cnt <= NW'(1);
    end else if ((state_next == pmd_pkg::ST_RELAX) && (state != pmd_pkg::ST_RELAX)) begin
      cnt <= '0;
    end else if ((state == pmd_pkg::ST_RELAX) || (state == pmd_pkg::ST_REPORT)) begin
      cnt <= cnt + NW'(1);
    end
  end

  // Weight matrix memory, one write and one registered read port.
  assign wr_addr = {VW'(in_item.row), VW'(in_item.col)};
  assign par_sel = cell_has[cnt[VW-1:0]] ? cell_par[cnt[VW-1:0]] : '0;
  assign rd_addr = rep_issue ? {cnt[VW-1:0], par_sel} : {u_reg, cnt[VW-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= WEIGHT_BITS'(in_item.weight) & WMASK;
    end
    rd_data <= mem[rd_addr];
  end

  // Read pipeline tags for relaxation and reporting.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_d  <= 1'b0;
      rep_vld_d <= 1'b0;
    end else begin
      rd_vld_d  <= relax_issue;
      rep_vld_d <= rep_issue;
    end
    rd_idx_d <= cnt[VW-1:0];
    rep_v    <= cnt[VW-1:0];
    rep_p    <= par_sel;
    rep_has  <= cell_has[cnt[VW-1:0]];
    rep_last <= (cnt == n_reg - NW'(1));
  end

  // Result transaction fields.
  assign result_valid       = rep_vld_d;
  assign result.vertex      = pmd_pkg::IDX_FW'(rep_v);
  assign result.parent      = pmd_pkg::IDX_FW'(rep_p);
  assign result.edge_weight = rep_has ? pmd_pkg::WEIGHT_FW'(rd_data) : '0;
  assign result.reached     = rep_has;
  assign result.last_edge   = rep_last;

  // Search token enters the head of the chain.
  assign tok_vld[0]   = tok_inject;
  assign tok_key[0]   = KEY_INF;
  assign tok_idx[0]   = '0;
  assign tok_found[0] = 1'b0;

  // Row of vertex cells.
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pmd_cell #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .my_idx        (VW'(i)),
      .n_act         (n_reg),
      .init          (cell_init),
      .mark_en       (mark_en),
      .mark_idx      (tok_idx[MAX_VERTICES]),
      .upd_en        (rd_vld_d),
      .upd_idx       (rd_idx_d),
      .upd_par       (u_reg),
      .upd_w         (rd_data),
      .tok_in_vld    (tok_vld[i]),
      .tok_in_key    (tok_key[i]),
      .tok_in_idx    (tok_idx[i]),
      .tok_in_found  (tok_found[i]),
      .tok_out_vld   (tok_vld[i+1]),
      .tok_out_key   (tok_key[i+1]),
      .tok_out_idx   (tok_idx[i+1]),
      .tok_out_found (tok_found[i+1]),
      .parent        (cell_par[i]),
      .has_parent    (cell_has[i])
    );
  end

endmodule

>>> sv/pmd_checker.sv
// Port-level checker of the spanning tree block and its bind.
`include "prim_mst_dense_assert.svh"

module pmd_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input pmd_pkg::in_item_t in_item,
  input logic              result_valid,
  input pmd_pkg::result_t  result
);

  // A result only appears while a run is in progress.
  `PMD_ASSERT_SAME(a_result_busy, result_valid, busy)
  // A matrix entry without last leaves the block ready.
  `PMD_ASSERT_NEXT(a_load_idle, start && !busy && !in_item.last, !busy && !result_valid)
  // The last entry starts a run.
  `PMD_ASSERT_NEXT(a_last_starts, start && !busy && in_item.last, busy)
  // Nothing follows the final result of a run.
  `PMD_ASSERT_NEXT(a_final_result, result_valid && result.last_edge, !result_valid)

endmodule

bind prim_mst_dense pmd_checker u_pmd_checker (.*);
